// ===== rtl/arpm_pkg.sv =====
// types and constants shared by the audio level meter
package arpm_pkg;
   localparam int SUM_W = 58;
   localparam int MAG_W = 23;
   localparam int LEN_W = 13;
   localparam int DEC_W = 16;
   localparam int LOGV_W = 64;
   localparam int FRAC_BITS = 24;
   localparam logic signed [15:0] DB_NEG_INF = 16'sh8000;
   localparam logic [27:0] C20_Q24 = 28'd101008905;
   localparam logic [27:0] C10_Q24 = 28'd50504453;
   localparam logic [1:0] CSR_BLOCK_LENGTH = 2'd0;
   localparam logic [1:0] CSR_DECAY = 2'd1;
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic        func;
      logic [2:0]  channel;
      logic signed [23:0] sample;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_channel;
      logic signed [15:0] rms_level_db;
      logic signed [15:0] peak_level_db;
   } rsp_type;

   // block-end job handed from accumulator to the dB unit
   typedef struct packed {
      logic [2:0]       channel;
      logic             neg_inf;
      logic [SUM_W-1:0] sum;
      logic [LEN_W+3:0] count;
      logic [MAG_W-1:0] peak;
   } job_type;
endpackage

// ===== rtl/arpm_front.sv =====
// per-channel accumulation, peak decay and block-end detection
module arpm_front #(
   parameter int CHANNELS = 8,
   parameter int MAX_BLOCK = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  arpm_pkg::req_type in_item,
   input  logic [arpm_pkg::LEN_W-1:0] block_length,
   input  logic [arpm_pkg::DEC_W-1:0] decay,
   input  logic job_ready,
   output logic job_valid,
   output arpm_pkg::job_type job
);
   import arpm_pkg::*;
   localparam int CW = 17;
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCK);

   logic [SUM_W-1:0] sum_ff [CHANNELS];
   logic [CW-1:0]    cnt_ff [CHANNELS];
   logic [MAG_W-1:0] bpk_ff [CHANNELS];
   logic [MAG_W-1:0] hpk_ff [CHANNELS];
   logic             jv_ff;
   job_type          job_ff;

   logic [23:0] s, neg;
   logic [MAG_W-1:0] mag, held_dec, newpk, bpk_new;
   logic [CW-1:0] len, cnt_new;
   logic [SUM_W-1:0] sum_new;
   logic [MAG_W+DEC_W-1:0] hprod;
   logic [6:0] ch;
   logic [IW-1:0] idx;
   logic ch_ok;

   always_comb begin
      ch = 7'(in_item.channel);
      ch_ok = ch < 7'(CHANNELS);
      idx = IW'(in_item.channel);
      s = in_item.sample;
      neg = 24'(25'h1000000 - {1'b0, s});
      if (s[23]) mag = (neg > 24'h7fffff) ? 23'h7fffff : neg[22:0];
      else mag = s[22:0];
      hprod = hpk_ff[idx] * decay;
      held_dec = hprod[MAG_W+DEC_W-1:DEC_W];
      len = (CW'(block_length) > MAXB) ? MAXB : CW'(block_length);
      sum_new = sum_ff[idx] + SUM_W'(mag * mag);
      cnt_new = cnt_ff[idx] + 1'b1;
      bpk_new = (mag > bpk_ff[idx]) ? mag : bpk_ff[idx];
      newpk = (bpk_new > held_dec) ? bpk_new : held_dec;
   end

   assign job_valid = jv_ff;
   assign job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         jv_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= '0; cnt_ff[i] <= '0; bpk_ff[i] <= '0; hpk_ff[i] <= '0;
         end
      end else begin
         if (job_ready) jv_ff <= 1'b0;
         if (in_valid) begin
            if (in_item.func == FUNC_CLEAR) begin
               for (int i = 0; i < CHANNELS; i++) hpk_ff[i] <= '0;
            end else if (ch_ok) begin
               job_ff.channel <= in_item.channel;
               if (len == '0) begin
                  sum_ff[idx] <= '0;
                  cnt_ff[idx] <= '0;
                  bpk_ff[idx] <= '0;
                  hpk_ff[idx] <= held_dec;
                  job_ff.neg_inf <= 1'b1;
                  jv_ff <= 1'b1;
               end else if (cnt_new >= len) begin
                  sum_ff[idx] <= '0;
                  cnt_ff[idx] <= '0;
                  bpk_ff[idx] <= '0;
                  hpk_ff[idx] <= newpk;
                  job_ff.neg_inf <= 1'b0;
                  job_ff.sum <= sum_new;
                  job_ff.count <= cnt_new;
                  job_ff.peak <= newpk;
                  jv_ff <= 1'b1;
               end else begin
                  sum_ff[idx] <= sum_new;
                  cnt_ff[idx] <= cnt_new;
                  bpk_ff[idx] <= bpk_new;
                  hpk_ff[idx] <= held_dec;
               end
            end
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      jv_ff && !job_ready |=> jv_ff) else $error("job lost");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= MAXB) else $error("count past block");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_item.func == FUNC_CLEAR |=> hpk_ff[0] == '0)
      else $error("clear missed");
`endif
endmodule

// ===== rtl/arpm_db.sv =====
// iterative log2 and dB conversion for completed blocks
module arpm_db (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  arpm_pkg::job_type job,
   output logic job_ready,
   output logic out_valid,
   output arpm_pkg::rsp_type out_item,
   input  logic out_pop
);
   import arpm_pkg::*;
   typedef enum logic [2:0] {S_IDLE, S_NORM, S_SQ, S_MUL, S_OUT} state_type;
   state_type state_ff;
   logic [1:0] which_ff;   // 0 sum, 1 count, 2 peak
   logic [LOGV_W-1:0] v_ff;
   logic [6:0] e_ff;
   logic [4:0] it_ff;
   logic [32:0] m_ff;
   logic [FRAC_BITS-1:0] fr_ff;
   logic signed [31:0] l_sum_ff, l_peak_ff;
   logic signed [63:0] p_ff;
   logic [1:0] mulph_ff;
   job_type j_ff;
   rsp_type r_ff;
   rsp_type o_ff;
   logic ov_ff;

   logic [65:0] sq;
   logic [32:0] msq;
   logic signed [31:0] lcur;
   logic signed [15:0] q;

   function automatic logic signed [15:0] to_q88(input logic signed [63:0] p);
      logic signed [63:0] t, qq;
      t = p + (64'sd1 <<< 39);
      qq = t >>> 40;
      if (qq < -64'sd32768) return DB_NEG_INF;
      if (qq > 64'sd32767) return 16'sd32767;
      return 16'(qq);
   endfunction

   always_comb begin
      sq = 66'(m_ff) * 66'(m_ff);
      msq = sq[63:31];
      lcur = 32'(signed'({25'd0, e_ff})) * 32'sd16777216 + 32'(signed'({1'b0, fr_ff}));
      q = to_q88(p_ff);
   end

   assign job_ready = state_ff == S_IDLE;
   assign out_valid = ov_ff;
   assign out_item = o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         if (out_pop && ov_ff) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (job_valid) begin
               j_ff <= job;
               if (job.neg_inf) begin
                  r_ff <= '{job.channel, DB_NEG_INF, DB_NEG_INF};
                  state_ff <= S_OUT;
               end else begin
                  which_ff <= 2'd0;
                  v_ff <= LOGV_W'(job.sum);
                  e_ff <= 7'd63;
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (e_ff != 0 && !v_ff[63]) begin
                  v_ff <= v_ff << 1; e_ff <= e_ff - 1'b1;
               end else begin
                  m_ff <= {1'b0, v_ff[63:32]};
                  fr_ff <= '0; it_ff <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (it_ff == 5'(FRAC_BITS)) begin
                  state_ff <= S_MUL; mulph_ff <= '0;
               end else begin
                  it_ff <= it_ff + 1'b1;
                  if (msq[32]) begin
                     m_ff <= msq >> 1; fr_ff <= {fr_ff[FRAC_BITS-2:0], 1'b1};
                  end else begin
                     m_ff <= msq; fr_ff <= {fr_ff[FRAC_BITS-2:0], 1'b0};
                  end
               end
            end
            S_MUL: begin
               mulph_ff <= mulph_ff + 1'b1;
               if (mulph_ff == 2'd0) begin
                  case (which_ff)
                     2'd0: begin
                        l_sum_ff <= lcur; which_ff <= 2'd1;
                        v_ff <= LOGV_W'(j_ff.count); e_ff <= 7'd63; state_ff <= S_NORM;
                     end
                     2'd1: begin
                        l_sum_ff <= l_sum_ff - lcur - 32'sd771751936;
                        which_ff <= 2'd2; v_ff <= LOGV_W'(j_ff.peak); e_ff <= 7'd63;
                        state_ff <= S_NORM;
                     end
                     default: l_peak_ff <= lcur - 32'sd385875968;
                  endcase
               end else if (mulph_ff == 2'd1) begin
                  p_ff <= 64'(l_peak_ff) * 64'(signed'({1'b0, C20_Q24}));
               end else if (mulph_ff == 2'd2) begin
                  r_ff.out_channel <= j_ff.channel;
                  r_ff.peak_level_db <= (j_ff.peak == '0) ? DB_NEG_INF : q;
                  p_ff <= 64'(l_sum_ff) * 64'(signed'({1'b0, C10_Q24}));
                  if (j_ff.sum == '0) begin
                     r_ff.rms_level_db <= DB_NEG_INF; mulph_ff <= 2'd0;
                     state_ff <= S_OUT;
                  end
                  if (j_ff.peak == '0 && j_ff.sum != '0) r_ff.peak_level_db <= DB_NEG_INF;
               end else begin
                  r_ff.rms_level_db <= q;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (!ov_ff || out_pop) begin
               o_ff <= r_ff;
               ov_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_pop |=> $stable(o_ff)) else $error("result changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !job_ready) else $error("ready while busy");
   a_it: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQ |-> it_ff <= 5'(FRAC_BITS)) else $error("iteration overrun");
`endif
endmodule

// ===== rtl/audio_rms_peak_meter.sv =====
// top level of the multichannel rms and peak level meter
// Samples are accumulated per channel at one item per cycle while full is low. When a block
// completes, the item is handed to a dB unit that normalizes and squares one bit per cycle,
// so its time per result is set by the bit lengths of the square sum, count and peak (a
// zero block length skips the conversion); the input stalls (full high) while a completed
// block waits for that unit. A result waits in an output register until popped, while the
// unit works on the next block.
module audio_rms_peak_meter #(
   parameter int CHANNELS = 8,
   parameter int MAX_BLOCK = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  arpm_pkg::req_type req_item,
   output logic empty,
   input  logic pop,
   output arpm_pkg::rsp_type rsp_item,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   import arpm_pkg::*;
   logic [LEN_W-1:0] len_ff;
   logic [DEC_W-1:0] dec_ff;
   logic jv, jr, ov;
   job_type job;

   assign csr_ready = 1'b1;
   assign full = jv;
   assign empty = !ov;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(256); dec_ff <= DEC_W'(65529);
      end else if (csr_valid) begin
         if (csr_index == CSR_BLOCK_LENGTH) len_ff <= csr_data[LEN_W-1:0];
         else if (csr_index == CSR_DECAY) dec_ff <= csr_data[DEC_W-1:0];
      end
   end

   arpm_front #(.CHANNELS(CHANNELS), .MAX_BLOCK(MAX_BLOCK)) u_front (
      .clock, .reset, .in_valid(push && !full), .in_item(req_item),
      .block_length(len_ff), .decay(dec_ff), .job_ready(jr),
      .job_valid(jv), .job);

   arpm_db u_db (
      .clock, .reset, .job_valid(jv), .job, .job_ready(jr),
      .out_valid(ov), .out_item(rsp_item), .out_pop(pop));
endmodule
